// ===== hw/rtl/dnt_pkg.sv =====
// shared types and constants for the directory name table
// no dependencies
`default_nettype none

package dnt_pkg;

  localparam int SECTOR_W = 16;
  localparam int KEY_IN_W = 64;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef logic [1:0] upd_op_t;
  localparam upd_op_t UPD_NONE  = 2'd0;
  localparam upd_op_t UPD_WRITE = 2'd1;
  localparam upd_op_t UPD_CLEAR = 2'd2;

  // names of the two fixed entries
  localparam logic [KEY_IN_W-1:0] NAME_DOT    = 64'h2E;
  localparam logic [KEY_IN_W-1:0] NAME_DOTDOT = 64'h2E2E;

  // search token flags passed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
    logic hit_dir;
    logic free_found;
  } scan_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dnt_cell.sv =====
// one slot of the directory name table plus its stage of the search token
// depends on dnt_pkg
`default_nettype none

module dnt_cell #(
  parameter int IDX   = 0,
  parameter int KEY_W = 64,
  parameter int IDX_W = 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [KEY_W-1:0]              key,
  input  dnt_pkg::upd_op_t             upd_op,
  input  wire [IDX_W-1:0]              upd_idx,
  input  wire [dnt_pkg::SECTOR_W-1:0]  upd_sector,
  input  wire                          upd_dir,
  input  dnt_pkg::scan_flags_t         flags_in,
  input  wire [IDX_W-1:0]              hit_idx_in,
  input  wire [dnt_pkg::SECTOR_W-1:0]  hit_sector_in,
  input  wire [IDX_W-1:0]              free_idx_in,
  output dnt_pkg::scan_flags_t         flags_out,
  output logic [IDX_W-1:0]             hit_idx_out,
  output logic [dnt_pkg::SECTOR_W-1:0] hit_sector_out,
  output logic [IDX_W-1:0]             free_idx_out
);
  import dnt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam bit FIXED = (IDX < 2);
  localparam logic [KEY_IN_W-1:0] RST_NAME = (IDX == 0) ? NAME_DOT : NAME_DOTDOT;

  logic                valid;
  logic [KEY_W-1:0]    name;
  logic [SECTOR_W-1:0] sector;
  logic                is_dir;
  logic                match;
  logic                sel;

  assign match = flags_in.valid && valid && (name == key);
  assign sel   = (upd_idx == MY_IDX);

  // slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= FIXED;
      if (FIXED) begin
        name   <= RST_NAME[KEY_W-1:0];
        is_dir <= 1'b1;
      end
    end else if (sel && upd_op == UPD_WRITE) begin
      valid  <= 1'b1;
      name   <= key;
      sector <= upd_sector;
      is_dir <= upd_dir;
    end else if (sel && upd_op == UPD_CLEAR) begin
      valid <= 1'b0;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out.valid <= flags_in.valid;
      flags_out.hit   <= flags_in.hit || match;
      if (!flags_in.hit && match) begin
        flags_out.hit_dir <= is_dir;
      end else begin
        flags_out.hit_dir <= flags_in.hit_dir;
      end
      flags_out.free_found <= flags_in.free_found || (!FIXED && !valid);
    end
  end

  always_ff @(posedge clk) begin
    if (!flags_in.hit && match) begin
      hit_idx_out    <= MY_IDX;
      hit_sector_out <= sector;
    end else begin
      hit_idx_out    <= hit_idx_in;
      hit_sector_out <= hit_sector_in;
    end
    if (!flags_in.free_found && !FIXED && !valid) begin
      free_idx_out <= MY_IDX;
    end else begin
      free_idx_out <= free_idx_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/directory_name_table.sv =====
// top level of the directory name table: command control and the row of slot cells
// depends on dnt_pkg and dnt_cell
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+----------------------
//  command   | command name_key new_sector new_is_dir        | start high, busy low
//  result    | status slot_index found_sector found_is_dir   | done, one cycle
//  config    | cfg_index cfg_data                            | cfg_we
//
// the search token walks the row of cells one slot a cycle, so the slot count
// sets how long an item takes from accept until busy falls; busy falls in the
// cycle after done. rst is synchronous and restores the two fixed entries.
// results cannot be held off; only one item is in flight.
`default_nettype none

module directory_name_table #(
  parameter int ENTRIES    = 64,
  parameter int NAME_CHARS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [dnt_pkg::SECTOR_W-1:0]  cfg_data,
  input  wire                          start,
  output logic                         busy,
  input  wire [dnt_pkg::CMD_W-1:0]     command,
  input  wire [dnt_pkg::KEY_IN_W-1:0]  name_key,
  input  wire [dnt_pkg::SECTOR_W-1:0]  new_sector,
  input  wire                          new_is_dir,
  output logic                         done,
  output logic [dnt_pkg::STATUS_W-1:0] status,
  output logic [dnt_pkg::SLOT_W-1:0]   slot_index,
  output logic [dnt_pkg::SECTOR_W-1:0] found_sector,
  output logic                         found_is_dir
);
  import dnt_pkg::*;

  localparam int KEY_W = 8 * NAME_CHARS;
  localparam int IDX_W = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]          state;
  logic                launch;
  logic [CMD_W-1:0]    cur_cmd;
  logic [KEY_W-1:0]    cur_key;
  logic [SECTOR_W-1:0] cur_sector;
  logic                cur_dir;
  logic [SECTOR_W-1:0] self_sector;
  logic [SECTOR_W-1:0] parent_sector;
  upd_op_t             upd_op;
  logic [IDX_W-1:0]    upd_idx;
  logic [KEY_IN_W-1:0] key_norm;
  logic                accept;

  scan_flags_t         flags_link  [ENTRIES+1];
  logic [IDX_W-1:0]    hidx_link   [ENTRIES+1];
  logic [SECTOR_W-1:0] hsec_link   [ENTRIES+1];
  logic [IDX_W-1:0]    fidx_link   [ENTRIES+1];

  scan_flags_t         tail;
  logic [IDX_W-1:0]    tail_hidx;
  logic [SECTOR_W-1:0] tail_hsec;
  logic [IDX_W-1:0]    tail_fidx;
  logic [SECTOR_W-1:0] hit_sec;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // cut the key at its first zero byte and after NAME_CHARS bytes
  always_comb begin
    logic alive;
    alive    = 1'b1;
    key_norm = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NAME_CHARS || name_key[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_norm[8*b +: 8] = name_key[8*b +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_sector   <= '0;
      parent_sector <= '0;
    end else if (cfg_we) begin
      if (cfg_index) begin
        parent_sector <= cfg_data;
      end else begin
        self_sector <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd    <= command;
      cur_key    <= key_norm[KEY_W-1:0];
      cur_sector <= new_sector;
      cur_dir    <= new_is_dir;
    end
  end

  // chain of slot cells
  always_comb begin
    flags_link[0]       = '0;
    flags_link[0].valid = launch;
    hidx_link[0]        = '0;
    hsec_link[0]        = '0;
    fidx_link[0]        = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dnt_cell #(
      .IDX   (i),
      .KEY_W (KEY_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .key            (cur_key),
      .upd_op         (upd_op),
      .upd_idx        (upd_idx),
      .upd_sector     (cur_sector),
      .upd_dir        (cur_dir),
      .flags_in       (flags_link[i]),
      .hit_idx_in     (hidx_link[i]),
      .hit_sector_in  (hsec_link[i]),
      .free_idx_in    (fidx_link[i]),
      .flags_out      (flags_link[i+1]),
      .hit_idx_out    (hidx_link[i+1]),
      .hit_sector_out (hsec_link[i+1]),
      .free_idx_out   (fidx_link[i+1])
    );
  end

  assign tail      = flags_link[ENTRIES];
  assign tail_hidx = hidx_link[ENTRIES];
  assign tail_hsec = hsec_link[ENTRIES];
  assign tail_fidx = fidx_link[ENTRIES];

  // fixed entries report their sectors from the registers
  always_comb begin
    if (tail_hidx == IDX_W'(0)) begin
      hit_sec = self_sector;
    end else if (tail_hidx == IDX_W'(1)) begin
      hit_sec = parent_sector;
    end else begin
      hit_sec = tail_hsec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
      upd_op <= UPD_NONE;
    end else begin
      launch <= accept;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.valid) begin
            done  <= 1'b1;
            state <= S_APPLY;
            if (cur_cmd == CMD_ADD && !tail.hit && tail.free_found) begin
              upd_op <= UPD_WRITE;
            end else if (cur_cmd == CMD_REMOVE && tail.hit) begin
              upd_op <= UPD_CLEAR;
            end
          end
        end
        S_APPLY: begin
          upd_op <= UPD_NONE;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result and update target
  always_ff @(posedge clk) begin
    if (state == S_SCAN && tail.valid) begin
      status       <= ST_NOT_FOUND;
      slot_index   <= '0;
      found_sector <= '0;
      found_is_dir <= 1'b0;
      upd_idx      <= tail_hidx;
      case (cur_cmd)
        CMD_LOOKUP: begin
          if (tail.hit) begin
            status       <= ST_OK;
            slot_index   <= SLOT_W'(tail_hidx);
            found_sector <= hit_sec;
            found_is_dir <= tail.hit_dir;
          end
        end
        CMD_ADD: begin
          if (tail.hit) begin
            status <= ST_PRESENT;
          end else if (tail.free_found) begin
            status     <= ST_OK;
            slot_index <= SLOT_W'(tail_fidx);
            upd_idx    <= tail_fidx;
          end else begin
            status <= ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (tail.hit) begin
            status     <= ST_OK;
            slot_index <= SLOT_W'(tail_hidx);
          end
        end
        default: begin
          status <= ST_NOT_FOUND;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
